@@ rtl/cse_pkg.sv @@
// Shared widths, codes, types and saturation helper for the Chebyshev series engine.
`default_nettype none

package cse_pkg;

    localparam int MODE_W  = 2;
    localparam int IDX_W   = 6;
    localparam int COEF_W  = 32;
    localparam int POINT_W = 18;
    localparam int T_W     = 18;
    localparam int ACC_W   = 40;
    localparam int TC_W    = 7;
    localparam int WIDE_W  = 64;

    localparam logic [MODE_W-1:0] MODE_LOAD       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIFF       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVAL       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EVAL_DERIV = 2'd3;

    localparam logic signed [WIDE_W-1:0] ACC_MAX = 64'sd549755813887;
    localparam logic signed [WIDE_W-1:0] ACC_MIN = -64'sd549755813888;

    // T0 in Q2.16.
    localparam logic signed [T_W-1:0] T_ONE = 18'sd65536;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    clip;
    } acc_sat_t;

    typedef struct packed {
        logic done;
        logic clip;
    } cse_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIFF,
        ST_HOLD
    } top_state_t;

    typedef enum logic [2:0] {
        EV_IDLE,
        EV_FETCH,
        EV_MUL,
        EV_ACC,
        EV_DONE
    } eval_state_t;

    function automatic acc_sat_t acc_saturate(input logic signed [WIDE_W-1:0] v);
        acc_sat_t r;
        if (v > ACC_MAX)
        begin
            r.value = ACC_MAX[ACC_W-1:0];
            r.clip  = 1'b1;
        end
        else if (v < ACC_MIN)
        begin
            r.value = ACC_MIN[ACC_W-1:0];
            r.clip  = 1'b1;
        end
        else
        begin
            r.value = v[ACC_W-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cse_in_if.sv @@
// Input channel: one command beat with its payload.
`default_nettype none

interface cse_in_if;
    import cse_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [IDX_W-1:0]          term_index;
    logic signed [COEF_W-1:0]  coefficient_value;
    logic signed [POINT_W-1:0] point;

    modport source (
        output valid, mode, term_index, coefficient_value, point,
        input  ready
    );

    modport sink (
        input  valid, mode, term_index, coefficient_value, point,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/cse_out_if.sv @@
// Output channel: one result beat with its payload.
`default_nettype none

interface cse_out_if;
    import cse_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] series_value;
    logic                    saturated;

    modport source (
        output valid, series_value, saturated,
        input  ready
    );

    modport sink (
        input  valid, series_value, saturated,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/cse_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/cse_eval.sv @@
// Series evaluator: walks the table with the three-term recurrence, a multiply state and an accumulate state per term.
`default_nettype none

module cse_eval #(
    parameter int unsigned MAX_TERMS = 64,
    localparam int AW = $clog2(MAX_TERMS),
    localparam int CW = AW + 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [cse_pkg::POINT_W-1:0] point,
    input  wire logic [CW-1:0]                    n,
    input  wire logic signed [cse_pkg::ACC_W-1:0] rdata,
    output logic [AW-1:0]                         raddr,
    output cse_pkg::cse_status_t                  status,
    output logic signed [cse_pkg::ACC_W-1:0]      value
);
    import cse_pkg::*;

    eval_state_t state_reg, state_next;

    logic [CW-1:0]            k_reg;
    logic [CW-1:0]            n_reg;
    logic                     clip_reg;
    logic signed [POINT_W-1:0] x_reg;
    logic signed [T_W-1:0]    cur_reg;
    logic signed [T_W-1:0]    prev_reg;
    logic signed [35:0]       txp_reg;
    logic signed [38:0]       mlo_reg;
    logic signed [37:0]       mhi_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [CW-1:0]            k_inc;
    logic                     last;
    logic signed [35:0]       txp_next;
    logic signed [38:0]       mlo_next;
    logic signed [37:0]       mhi_next;
    logic signed [57:0]       prod;
    logic signed [57:0]       prod_rnd;
    acc_sat_t                 acc_sat;
    logic signed [35:0]       t_rnd;
    logic signed [21:0]       t_diff;
    logic signed [T_W-1:0]    t_next;
    logic                     t_clip;

    assign k_inc = k_reg + CW'(1);
    assign last  = (k_inc == n_reg);

    // The coefficient is split so each product stays a narrow multiplier.
    assign mlo_next = cur_reg * $signed({1'b0, rdata[19:0]});
    assign mhi_next = cur_reg * $signed(rdata[39:20]);
    assign txp_next = x_reg * cur_reg;

    assign prod     = (58'(mhi_reg) <<< 20) + 58'(mlo_reg);
    assign prod_rnd = prod + 58'sd32768;
    assign acc_sat  = acc_saturate(64'(acc_reg) + 64'($signed(prod_rnd[57:16])));

    // Rounding 2*x*T at bit 16 is the same as rounding x*T at bit 15.
    assign t_rnd  = txp_reg + 36'sd16384;
    assign t_diff = 22'($signed(t_rnd[35:15])) - 22'(prev_reg);

    always_comb
    begin
        if (t_diff > 22'sd131071)
        begin
            t_next = 18'sd131071;
            t_clip = 1'b1;
        end
        else if (t_diff < -22'sd131072)
        begin
            t_next = -18'sd131072;
            t_clip = 1'b1;
        end
        else
        begin
            t_next = t_diff[T_W-1:0];
            t_clip = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EV_IDLE:
            begin
                if (start)
                begin
                    state_next = (n == '0) ? EV_DONE : EV_FETCH;
                end
            end
            EV_FETCH: state_next = EV_MUL;
            EV_MUL:   state_next = EV_ACC;
            EV_ACC:   state_next = last ? EV_DONE : EV_MUL;
            EV_DONE:  state_next = EV_IDLE;
            default:  state_next = EV_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            EV_ACC:  raddr = AW'(k_inc);
            default: raddr = AW'(k_reg);
        endcase
        status.done = (state_reg == EV_DONE);
        status.clip = clip_reg;
        value       = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EV_IDLE;
            k_reg     <= '0;
            clip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == EV_IDLE && start)
            begin
                k_reg    <= '0;
                clip_reg <= 1'b0;
            end
            else if (state_reg == EV_ACC)
            begin
                k_reg    <= k_inc;
                // A polynomial value past the last term is never used, so it cannot clip.
                clip_reg <= clip_reg | acc_sat.clip | (t_clip & ~last);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == EV_IDLE && start)
        begin
            x_reg    <= point;
            n_reg    <= n;
            cur_reg  <= T_ONE;
            // With T(-1) = x the recurrence yields T1 = x.
            prev_reg <= point;
            acc_reg  <= '0;
        end
        else if (state_reg == EV_MUL)
        begin
            mlo_reg <= mlo_next;
            mhi_reg <= mhi_next;
            txp_reg <= txp_next;
        end
        else if (state_reg == EV_ACC)
        begin
            acc_reg  <= acc_sat.value;
            prev_reg <= cur_reg;
            cur_reg  <= t_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cse_diff.sv @@
// Derivative builder: backward recurrence over the coefficients, one term per cycle.
`default_nettype none

module cse_diff #(
    parameter int unsigned MAX_TERMS = 64,
    localparam int AW = $clog2(MAX_TERMS),
    localparam int CW = AW + 1,
    localparam int PW = cse_pkg::COEF_W + CW + 2
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [CW-1:0]                     n,
    input  wire logic signed [cse_pkg::COEF_W-1:0] rdata,
    output logic [AW-1:0]                          raddr,
    output logic                                   we,
    output logic [AW-1:0]                          waddr,
    output logic [cse_pkg::ACC_W-1:0]              wdata,
    output cse_pkg::cse_status_t                   status,
    output logic [CW-1:0]                          dlen,
    output logic                                   dzero
);
    import cse_pkg::*;

    logic                    issue_reg;
    logic [CW-1:0]           k_reg;
    logic                    s1_valid_reg;
    logic [CW-1:0]           s1_k_reg;
    logic                    s2_valid_reg;
    logic [CW-1:0]           s2_k_reg;
    logic                    done_reg;
    logic                    clip_reg;
    logic [CW-1:0]           dlen_reg;
    logic                    dzero_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] d1_reg;
    logic signed [ACC_W-1:0] d2_reg;

    logic [CW-1:0]           k_inc;
    logic [CW-1:0]           s1_kp1;
    logic signed [CW+1:0]    factor;
    logic signed [PW-1:0]    prod_next;
    acc_sat_t                sum_sat;
    logic signed [ACC_W:0]   half;

    assign k_inc     = k_reg + CW'(1);
    assign s1_kp1    = s1_k_reg + CW'(1);
    assign factor    = $signed({1'b0, s1_kp1, 1'b0});
    assign prod_next = rdata * factor;

    // Terms beyond the top of the series read as zero through the cleared d1/d2 pair.
    assign sum_sat = acc_saturate(64'(d2_reg) + 64'(prod_reg));
    assign half    = 41'($signed(sum_sat.value)) + 41'sd1;

    assign raddr  = AW'(k_inc);
    assign we     = s2_valid_reg;
    assign waddr  = AW'(s2_k_reg);
    assign wdata  = (s2_k_reg == '0) ? half[ACC_W:1] : sum_sat.value;

    assign status.done = done_reg;
    assign status.clip = clip_reg;
    assign dlen        = dlen_reg;
    assign dzero       = dzero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s1_k_reg     <= '0;
            s2_valid_reg <= 1'b0;
            s2_k_reg     <= '0;
            done_reg     <= 1'b0;
            clip_reg     <= 1'b0;
            dlen_reg     <= CW'(1);
            dzero_reg    <= 1'b1;
        end
        else
        begin
            done_reg     <= 1'b0;
            s1_valid_reg <= issue_reg;
            s1_k_reg     <= k_reg;
            s2_valid_reg <= s1_valid_reg;
            s2_k_reg     <= s1_k_reg;

            if (start)
            begin
                clip_reg <= 1'b0;
                if (n < CW'(2))
                begin
                    dlen_reg  <= CW'(1);
                    dzero_reg <= 1'b1;
                    done_reg  <= 1'b1;
                end
                else
                begin
                    dlen_reg  <= n - CW'(1);
                    dzero_reg <= 1'b0;
                    issue_reg <= 1'b1;
                    k_reg     <= n - CW'(2);
                end
            end
            else if (issue_reg)
            begin
                if (k_reg == '0)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg - CW'(1);
                end
            end

            if (s2_valid_reg)
            begin
                clip_reg <= clip_reg | sum_sat.clip;
                if (s2_k_reg == '0)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            d2_reg <= d1_reg;
            d1_reg <= sum_sat.value;
        end
        if (s1_valid_reg)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/chebyshev_series_engine.sv @@
// Top level: command dispatch, coefficient and derivative memories, result register.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+-------------------------------------------------
//   item      | in  | valid / ready | mode, term_index, coefficient_value, point
//   result    | out | valid / ready | series_value, saturated
//   cfg_write | in  | write enable  | term_count (7 bits), no read-back
//
// A load beat is written to the coefficient memory in the cycle it is accepted, if its term
// index is below MAX_TERMS. An evaluation steps each term through one multiply state and one
// accumulate state, as the serial T(k) recurrence requires.
// Differentiation makes one coefficient memory read per derivative term.
// No clearing pass after reset; a single zero derivative term is tracked by a flag.
// One beat is worked on at a time; a finished result waits in the output register while
// the next beat is taken.
`default_nettype none

module chebyshev_series_engine #(
    parameter int unsigned MAX_TERMS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    cse_in_if.sink                             item,
    cse_out_if.source                          result,
    input  wire logic                          cfg_write_en,
    input  wire logic [cse_pkg::TC_W-1:0]      cfg_write_data
);
    import cse_pkg::*;

    localparam int AW = $clog2(MAX_TERMS);
    localparam int CW = AW + 1;

    top_state_t state_reg, state_next;

    logic [TC_W-1:0]         term_count_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic                    out_valid_reg;
    logic signed [ACC_W-1:0] out_value_reg;
    logic                    out_sat_reg;

    logic                    accept;
    logic                    eval_start;
    logic                    diff_start;
    logic                    coef_we;
    logic                    out_load;
    logic [CW-1:0]           n_eff;
    logic [CW-1:0]           eval_n;

    logic [AW-1:0]           coef_waddr;
    logic [AW-1:0]           coef_raddr;
    logic [COEF_W-1:0]       coef_rdata;
    logic [ACC_W-1:0]        deriv_rdata;
    logic signed [ACC_W-1:0] eval_rdata;

    logic [AW-1:0]           eval_raddr;
    cse_status_t             eval_status;
    logic signed [ACC_W-1:0] eval_value;

    logic [AW-1:0]           diff_raddr;
    logic                    diff_we;
    logic [AW-1:0]           diff_waddr;
    logic [ACC_W-1:0]        diff_wdata;
    cse_status_t             diff_status;
    logic [CW-1:0]           dlen;
    logic                    dzero;

    assign accept = item.valid & item.ready;
    assign n_eff  = (32'(term_count_reg) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(term_count_reg);
    assign eval_n = (item.mode == MODE_EVAL_DERIV) ? dlen : n_eff;
    assign coef_waddr = AW'(item.term_index);
    assign coef_raddr = (state_reg == ST_DIFF) ? diff_raddr : eval_raddr;

    always_comb
    begin
        if (mode_reg == MODE_EVAL_DERIV)
        begin
            eval_rdata = dzero ? '0 : $signed(deriv_rdata);
        end
        else
        begin
            eval_rdata = 40'($signed(coef_rdata));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.mode)
                        MODE_DIFF:                  state_next = ST_DIFF;
                        MODE_EVAL, MODE_EVAL_DERIV: state_next = ST_EVAL;
                        default:                    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (eval_status.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_DIFF:
            begin
                if (diff_status.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item.ready = (state_reg == ST_IDLE);
        eval_start = accept && (item.mode == MODE_EVAL || item.mode == MODE_EVAL_DERIV);
        diff_start = accept && (item.mode == MODE_DIFF);
        coef_we    = accept && (item.mode == MODE_LOAD) && (32'(item.term_index) < MAX_TERMS);
        out_load   = (state_reg == ST_HOLD) && (!out_valid_reg || result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            term_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                term_count_reg <= cfg_write_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= item.mode;
        end
        if (out_load)
        begin
            // A differentiate beat reports only its clip flag, with a zero value.
            if (mode_reg == MODE_DIFF)
            begin
                out_value_reg <= '0;
                out_sat_reg   <= diff_status.clip;
            end
            else
            begin
                out_value_reg <= eval_value;
                out_sat_reg   <= eval_status.clip;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.series_value = out_value_reg;
    assign result.saturated    = out_sat_reg;

    cse_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TERMS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (item.coefficient_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    cse_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_TERMS)
    ) u_deriv_ram (
        .clk   (clk),
        .we    (diff_we),
        .waddr (diff_waddr),
        .wdata (diff_wdata),
        .raddr (eval_raddr),
        .rdata (deriv_rdata)
    );

    cse_eval #(
        .MAX_TERMS (MAX_TERMS)
    ) u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (eval_start),
        .point  (item.point),
        .n      (eval_n),
        .rdata  (eval_rdata),
        .raddr  (eval_raddr),
        .status (eval_status),
        .value  (eval_value)
    );

    cse_diff #(
        .MAX_TERMS (MAX_TERMS)
    ) u_diff (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (diff_start),
        .n      (n_eff),
        .rdata  ($signed(coef_rdata)),
        .raddr  (diff_raddr),
        .we     (diff_we),
        .waddr  (diff_waddr),
        .wdata  (diff_wdata),
        .status (diff_status),
        .dlen   (dlen),
        .dzero  (dzero)
    );

endmodule

`default_nettype wire
